@@ rtl/core/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

   localparam int ByteW     = 8;
   localparam int CodePtW   = 21;
   localparam int PendW     = 2;
   localparam int QDepth    = 4;
   localparam int QPtrW     = $clog2(QDepth);
   localparam int QCntW     = $clog2(QDepth + 1);

   localparam logic [CodePtW-1:0] ReplChar   = 21'h00FFFD;
   localparam logic [ByteW-1:0]   ContMask   = 8'h3F;
   localparam logic [ByteW-1:0]   Lead2Mask  = 8'h1F;
   localparam logic [ByteW-1:0]   Lead3Mask  = 8'h0F;
   localparam logic [ByteW-1:0]   Lead4Mask  = 8'h07;

   // Byte classes found by the front end
   typedef enum logic [2:0] {
      CLS_ASCII   = 3'd0,
      CLS_CONT    = 3'd1,
      CLS_LEAD2   = 3'd2,
      CLS_LEAD3   = 3'd3,
      CLS_LEAD4   = 3'd4,
      CLS_INVALID = 3'd5
   } byte_class_type;

   // One classified byte as it sits in the queue
   typedef struct packed {
      byte_class_type    cls;
      logic [ByteW-1:0]  in_byte;
      logic              end_of_string;
   } item_type;

   // Write side of the queue
   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   // Read side of the queue
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // One result beat
   typedef struct packed {
      logic [CodePtW-1:0] code_point;
      logic               is_replacement;
      logic               last_of_run;
   } result_type;

endpackage

@@ rtl/core/u8d_ifs.sv @@
// ----------------------------------------------------------------------------
// u8d channel interfaces
// Valid/ready channels for input bytes and decoded code points.
// ----------------------------------------------------------------------------
interface u8d_req_if import u8d_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] in_byte;
   logic             end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u8d_rsp_if import u8d_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CodePtW-1:0] code_point;
   logic               is_replacement;
   logic               last_of_run;

   modport source (output valid, output code_point, output is_replacement,
                   output last_of_run, input ready);
   modport sink   (input valid, input code_point, input is_replacement,
                   input last_of_run, output ready);
endinterface

@@ rtl/core/utf8_to_code_point_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder
// Decodes a UTF-8 byte stream into 21-bit code points, one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one byte per beat plus an end-of-string mark. rsp_ch
//   returns code points; U+FFFD with is_replacement set stands for malformed
//   input, and last_of_run marks the final result caused by a byte.
//   A byte yields zero, one or two results; lead bytes and unfinished
//   continuations yield none unless they end the string.
// Path: a taken byte waits in the queue, and its first result is then
//   registered in the output register before it is valid on rsp_ch.
// Throughput: one byte per cycle while rsp_ch is ready; a byte that yields
//   two results holds the next byte in the queue until its second result
//   has moved into the output register, as there is a single result port.
// A four-entry queue parts classification from decoding, so req_ch keeps
//   taking bytes while rsp_ch stalls until the queue fills; then req_ch.ready
//   drops. A stalled result holds its payload.
// Reset (synchronous, active high) empties the queue and output register and
//   clears the pending count and the accumulator.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder import u8d_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   u8d_req_if.sink   req_ch,
   u8d_rsp_if.source rsp_ch
);

   push_type push;
   head_type head;
   logic     q_full;
   logic     pop;

   u8d_front u_front (
      .req_ch (req_ch),
      .q_full (q_full),
      .push   (push)
   );

   u8d_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   u8d_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

@@ rtl/core/u8d_front.sv @@
// ----------------------------------------------------------------------------
// u8d_front
// Accepts input beats, classifies each byte and pushes it into the queue.
// ----------------------------------------------------------------------------
module u8d_front import u8d_pkg::*; (
   u8d_req_if.sink  req_ch,
   input  logic     q_full,
   output push_type push
);

   byte_class_type cls;

   // Classify the byte by its leading bits
   always_comb begin
      case (req_ch.in_byte) inside
         [8'h00:8'h7F]: cls = CLS_ASCII;
         [8'h80:8'hBF]: cls = CLS_CONT;
         [8'hC0:8'hDF]: cls = CLS_LEAD2;
         [8'hE0:8'hEF]: cls = CLS_LEAD3;
         [8'hF0:8'hF7]: cls = CLS_LEAD4;
         default:       cls = CLS_INVALID;
      endcase
   end

   // Take a beat whenever the queue has room
   assign req_ch.ready            = ~q_full;
   assign push.valid              = req_ch.valid & ~q_full;
   assign push.item.cls           = cls;
   assign push.item.in_byte       = req_ch.in_byte;
   assign push.item.end_of_string = req_ch.end_of_string;

endmodule

@@ rtl/core/u8d_queue.sv @@
// ----------------------------------------------------------------------------
// u8d_queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module u8d_queue import u8d_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     full,
   output head_type head
);

   item_type         entry_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == QCntW'(QDepth));
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   assign do_push = push.valid & ~full;
   assign do_pop  = pop & head.valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPtrW'(do_push);
      rd_ptr_in = rd_ptr_ff + QPtrW'(do_pop);
      count_in  = count_ff + QCntW'(do_push) - QCntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

@@ rtl/core/u8d_back.sv @@
// ----------------------------------------------------------------------------
// u8d_back
// Holds the decode state, turns each classified byte into up to two results
// and drives the result channel through an output register.
// ----------------------------------------------------------------------------
module u8d_back import u8d_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  head_type head,
   output logic     pop,
   u8d_rsp_if.source rsp_ch
);

   logic [PendW-1:0]   pend_ff,  pend_in;
   logic [CodePtW-1:0] acc_ff,   acc_in;
   logic               out_vld_ff, out_vld_in;
   result_type         out_ff,   out_in;
   logic               sec_vld_ff, sec_vld_in;
   result_type         sec_ff,   sec_in;

   logic               out_free;
   logic               e0_vld, e1_vld;
   result_type         e0, e1;
   logic [PendW-1:0]   pend_nx;
   logic [CodePtW-1:0] acc_nx;
   logic [CodePtW-1:0] acc_shift;
   logic [ByteW-1:0]   b;

   assign out_free = ~out_vld_ff | rsp_ch.ready;
   assign pop      = head.valid & out_free & ~sec_vld_ff;
   assign b        = head.item.in_byte;
   assign acc_shift = {acc_ff[CodePtW-7:0], b[5:0] & ContMask[5:0]};

   // Decode one byte against the current state
   always_comb begin
      pend_nx = pend_ff;
      acc_nx  = acc_ff;
      e0_vld  = 1'b0;
      e1_vld  = 1'b0;
      e0      = '{code_point: ReplChar, is_replacement: 1'b1, last_of_run: 1'b0};
      e1      = '{code_point: ReplChar, is_replacement: 1'b1, last_of_run: 1'b1};

      case (head.item.cls)
         CLS_ASCII: begin
            if (pend_ff != '0) begin
               e0_vld = 1'b1;
               e1_vld = 1'b1;
               e1     = '{code_point: CodePtW'(b), is_replacement: 1'b0,
                          last_of_run: 1'b1};
            end else begin
               e0_vld = 1'b1;
               e0     = '{code_point: CodePtW'(b), is_replacement: 1'b0,
                          last_of_run: 1'b0};
            end
            pend_nx = '0;
         end
         CLS_CONT: begin
            if (pend_ff != '0) begin
               acc_nx  = acc_shift;
               pend_nx = pend_ff - PendW'(1);
               if (pend_ff == PendW'(1)) begin
                  e0_vld = 1'b1;
                  e0     = '{code_point: acc_shift, is_replacement: 1'b0,
                             last_of_run: 1'b0};
               end
            end else begin
               e0_vld = 1'b1;
            end
         end
         CLS_LEAD2: begin
            pend_nx = PendW'(1);
            acc_nx  = CodePtW'(b & Lead2Mask);
         end
         CLS_LEAD3: begin
            pend_nx = PendW'(2);
            acc_nx  = CodePtW'(b & Lead3Mask);
         end
         CLS_LEAD4: begin
            pend_nx = PendW'(3);
            acc_nx  = CodePtW'(b & Lead4Mask);
         end
         default: begin
            e0_vld  = 1'b1;
            pend_nx = '0;
         end
      endcase

      // Close the string: flag an unfinished sequence, clear the state
      if (head.item.end_of_string) begin
         if (pend_nx != '0) begin
            if (e0_vld) begin
               e1_vld = 1'b1;
               e1     = '{code_point: ReplChar, is_replacement: 1'b1,
                          last_of_run: 1'b1};
            end else begin
               e0_vld = 1'b1;
               e0     = '{code_point: ReplChar, is_replacement: 1'b1,
                          last_of_run: 1'b0};
            end
         end
         pend_nx = '0;
         acc_nx  = '0;
      end

      e0.last_of_run = ~e1_vld;
   end

   // Select what goes to the output register
   always_comb begin
      pend_in    = pend_ff;
      acc_in     = acc_ff;
      out_in     = out_ff;
      sec_in     = sec_ff;
      sec_vld_in = sec_vld_ff;
      out_vld_in = out_vld_ff & ~rsp_ch.ready;

      if (sec_vld_ff && out_free) begin
         out_vld_in = 1'b1;
         out_in     = sec_ff;
         sec_vld_in = 1'b0;
      end else if (pop) begin
         pend_in    = pend_nx;
         acc_in     = acc_nx;
         out_vld_in = e0_vld;
         out_in     = e0;
         sec_vld_in = e1_vld;
         sec_in     = e1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= '0;
         acc_ff     <= '0;
         out_vld_ff <= 1'b0;
         sec_vld_ff <= 1'b0;
      end else begin
         pend_ff    <= pend_in;
         acc_ff     <= acc_in;
         out_vld_ff <= out_vld_in;
         sec_vld_ff <= sec_vld_in;
      end
   end

   // Hold result payloads
   always_ff @(posedge clock) begin
      out_ff <= out_in;
      sec_ff <= sec_in;
   end

   assign rsp_ch.valid          = out_vld_ff;
   assign rsp_ch.code_point     = out_ff.code_point;
   assign rsp_ch.is_replacement = out_ff.is_replacement;
   assign rsp_ch.last_of_run    = out_ff.last_of_run;

endmodule
